// File: rtl/mbc1_pkg.sv
// ----------------------------------------------------------------------------
// mbc1_pkg
// Shared types, codes and constants of the MBC1 bank controller.
// ----------------------------------------------------------------------------
package mbc1_pkg;

	// Bus access kinds on the request channel
	localparam logic [1:0] FUNC_ROM_RD = 2'd0;
	localparam logic [1:0] FUNC_ROM_WR = 2'd1;
	localparam logic [1:0] FUNC_RAM_RD = 2'd2;
	localparam logic [1:0] FUNC_RAM_WR = 2'd3;

	// Register regions of a ROM write, selected by addr[14:13] below 0x8000
	localparam logic [1:0] REGION_RAM_EN  = 2'd0;
	localparam logic [1:0] REGION_ROM_LO  = 2'd1;
	localparam logic [1:0] REGION_UPPER   = 2'd2;
	localparam logic [1:0] REGION_MODE    = 2'd3;

	// Configuration register indexes
	localparam logic CFG_ROM_BANK_BITS  = 1'b0;
	localparam logic CFG_RAM_BANK_COUNT = 1'b1;

	// Field widths
	localparam int ROM_ADDR_W  = 21;
	localparam int ROM_BANK_W  = 7;
	localparam int ROM_OFS_W   = 14;
	localparam int RAM_OFS_W   = 13;
	localparam int RAM_BANK_W  = 2;
	localparam int CFG_W       = 3;

	// Defaults for the top-level parameters
	localparam int DEF_RAM_BANKS         = 4;
	localparam int DEF_MAX_ROM_BANK_BITS = 7;

	// Decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Bank register constants
	localparam logic [7:0]            RAM_EN_KEY    = 8'h0A;
	localparam logic [ROM_BANK_W-1:0] ROM_BANK_HI   = 7'h60;
	localparam logic [4:0]            ROM_LO_ONE    = 5'h01;
	localparam logic [7:0]            RAM_OFF_DATA  = 8'hFF;

	// Classified operation
	typedef enum logic [3:0] {
		OP_ROM_RD_FIXED,
		OP_ROM_RD_SWITCH,
		OP_SET_RAM_EN,
		OP_SET_ROM_LO,
		OP_SET_UPPER,
		OP_SET_MODE,
		OP_UNMAPPED,
		OP_RAM_RD,
		OP_RAM_WR
	} mbc1_op_t;

	// Command passed from front to back
	typedef struct packed {
		mbc1_op_t              op;
		logic [ROM_OFS_W-1:0]  ofs;
		logic [7:0]            data;
	} mbc1_cmd_t;

endpackage

// File: rtl/mbc1_req_if.sv
// ----------------------------------------------------------------------------
// mbc1_req_if
// Request channel: one bus access per transaction.
// ----------------------------------------------------------------------------
interface mbc1_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] addr;
	logic [7:0]  data;

	modport source (output valid, func, addr, data, input ready);
	modport sink   (input valid, func, addr, data, output ready);
endinterface

// File: rtl/mbc1_rsp_if.sv
// ----------------------------------------------------------------------------
// mbc1_rsp_if
// Response channel: one result per accepted bus access.
// ----------------------------------------------------------------------------
interface mbc1_rsp_if;
	logic        valid;
	logic        ready;
	logic [20:0] rom_address;
	logic [7:0]  read_data;
	logic        unmapped;

	modport source (output valid, rom_address, read_data, unmapped, input ready);
	modport sink   (input valid, rom_address, read_data, unmapped, output ready);
endinterface

// File: rtl/mbc1_bank_controller_top.sv
// ----------------------------------------------------------------------------
// mbc1_bank_controller_top
// MBC1 cartridge bank controller with an internal banked RAM store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one CPU bus access per transaction (func, addr, data); rsp
//   returns exactly one result per access, in order (rom_address, read_data,
//   unmapped). The cfg port writes rom_bank_bits (index 0) and
//   ram_bank_count (index 1); write them only while no access is in flight.
//   A request passes the queue stage, then the execute/RAM read stage,
//   before its response transaction is offered on rsp.
//   Throughput: one transaction per cycle, sustained, as long as rsp is
//   ready; the single RAM port serves one read or write per cycle.
//   When rsp stalls the result holds in its output register and the
//   two-entry command queue absorbs further requests; req.ready drops once
//   the queue is full.
//   Reset clears the bank registers (RAM disabled, mode 0, ROM bank 1, RAM
//   bank 0) and the configuration (one-value defaults). RAM contents are
//   not cleared and are undefined until written; no clearing pass is run.
// ----------------------------------------------------------------------------
module mbc1_bank_controller_top import mbc1_pkg::*; #(
	parameter int RAM_BANKS         = DEF_RAM_BANKS,
	parameter int MAX_ROM_BANK_BITS = DEF_MAX_ROM_BANK_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	mbc1_req_if.sink         req,
	mbc1_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      q_valid;
	mbc1_cmd_t front_cmd;
	mbc1_cmd_t head_cmd;

	// Accept and classify
	mbc1_front u_front (
		.req  (req),
		.full (q_full),
		.push (q_push),
		.cmd  (front_cmd)
	);

	// Decoupling queue
	mbc1_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (front_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (head_cmd)
	);

	// Execute and respond
	mbc1_back #(
		.RAM_BANKS         (RAM_BANKS),
		.MAX_ROM_BANK_BITS (MAX_ROM_BANK_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.pop       (q_pop),
		.rsp       (rsp)
	);

endmodule

// File: rtl/mbc1_front.sv
// ----------------------------------------------------------------------------
// mbc1_front
// Accepts bus accesses and classifies them into bank controller commands.
// ----------------------------------------------------------------------------
module mbc1_front import mbc1_pkg::*; (
	mbc1_req_if.sink   req,
	input  logic       full,
	output logic       push,
	output mbc1_cmd_t  cmd
);

	// Accept whenever the queue has room
	assign req.ready = !full;
	assign push      = req.valid && !full;

	// Decode function and address region
	always_comb begin
		cmd.ofs  = req.addr[ROM_OFS_W-1:0];
		cmd.data = req.data;
		cmd.op   = OP_ROM_RD_FIXED;
		unique case (req.func)
			FUNC_ROM_RD: begin
				cmd.op = (req.addr[15:14] == 2'b00) ? OP_ROM_RD_FIXED : OP_ROM_RD_SWITCH;
			end
			FUNC_ROM_WR: begin
				if (req.addr[15]) begin
					cmd.op = OP_UNMAPPED;
				end else begin
					unique case (req.addr[14:13])
						REGION_RAM_EN: cmd.op = OP_SET_RAM_EN;
						REGION_ROM_LO: cmd.op = OP_SET_ROM_LO;
						REGION_UPPER:  cmd.op = OP_SET_UPPER;
						REGION_MODE:   cmd.op = OP_SET_MODE;
						default:       cmd.op = OP_UNMAPPED;
					endcase
				end
			end
			FUNC_RAM_RD: cmd.op = OP_RAM_RD;
			FUNC_RAM_WR: cmd.op = OP_RAM_WR;
			default:     cmd.op = OP_ROM_RD_FIXED;
		endcase
	end

endmodule

// File: rtl/mbc1_cmd_queue.sv
// ----------------------------------------------------------------------------
// mbc1_cmd_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module mbc1_cmd_queue import mbc1_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mbc1_cmd_t  push_cmd,
	input  logic       pop,
	output logic       full,
	output logic       head_valid,
	output mbc1_cmd_t  head
);

	mbc1_cmd_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/mbc1_back.sv
// ----------------------------------------------------------------------------
// mbc1_back
// Executes commands: bank registers, ROM address mapping, banked RAM store,
// and the registered result stage.
// ----------------------------------------------------------------------------
module mbc1_back import mbc1_pkg::*; #(
	parameter int RAM_BANKS         = DEF_RAM_BANKS,
	parameter int MAX_ROM_BANK_BITS = DEF_MAX_ROM_BANK_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             cmd_valid,
	input  mbc1_cmd_t        cmd,
	output logic             pop,
	mbc1_rsp_if.source       rsp
);

	localparam int RAM_DEPTH = RAM_BANKS * (2 ** RAM_OFS_W);
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	// Configuration and bank registers
	logic [CFG_W-1:0]      cfg_rom_bits_q;
	logic [CFG_W-1:0]      cfg_ram_cnt_q;
	logic                  ram_en_q;
	logic                  bank_mode_q;
	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [RAM_BANK_W-1:0] ram_blk_q;

	// Result stage
	logic                  valid_s2;
	mbc1_op_t              op_s2;
	logic [ROM_ADDR_W-1:0] rom_addr_s2;
	logic                  ram_en_s2;
	logic [7:0]            rd_data_q;

	logic [7:0]            ram_q [RAM_DEPTH];

	logic                  issue;
	logic [CFG_W-1:0]      rom_bits;
	logic [CFG_W-1:0]      ram_cnt;
	logic [ROM_BANK_W-1:0] rom_mask;
	logic [ROM_BANK_W-1:0] rd_bank;
	logic [RAM_BANK_W-1:0] ram_sel;
	logic [RAM_BANK_W+RAM_OFS_W-1:0] ram_idx_full;
	logic [RAM_AW-1:0]     ram_idx;
	logic [4:0]            lo_bits;
	logic [1:0]            up_mask;

	// Take the queue head when the result stage is free or draining
	assign issue = cmd_valid && (!valid_s2 || rsp.ready);
	assign pop   = issue;

	// Effective configuration, saturated to the built sizes
	assign rom_bits = (cfg_rom_bits_q > CFG_W'(MAX_ROM_BANK_BITS)) ?
		CFG_W'(MAX_ROM_BANK_BITS) : cfg_rom_bits_q;
	assign ram_cnt  = (cfg_ram_cnt_q > CFG_W'(RAM_BANKS)) ? CFG_W'(RAM_BANKS) : cfg_ram_cnt_q;
	assign rom_mask = ROM_BANK_W'((8'd1 << rom_bits) - 8'd1);

	// ROM read bank: fixed area uses upper bits only in mode 1
	always_comb begin
		if (cmd.op == OP_ROM_RD_FIXED) begin
			rd_bank = bank_mode_q ? (rom_bank_q & ROM_BANK_HI) : '0;
		end else begin
			rd_bank = rom_bank_q;
		end
		rd_bank = rd_bank & rom_mask;
	end

	// RAM bank select, reduced modulo the effective bank count
	always_comb begin
		ram_sel = '0;
		if (bank_mode_q && ram_cnt > 3'd1) begin
			case (ram_cnt)
				3'd2:    ram_sel = {1'b0, ram_blk_q[0]};
				3'd3:    ram_sel = (ram_blk_q == 2'd3) ? '0 : ram_blk_q;
				default: ram_sel = ram_blk_q;
			endcase
		end
	end

	assign ram_idx_full = {ram_sel, cmd.ofs[RAM_OFS_W-1:0]};
	assign ram_idx      = ram_idx_full[RAM_AW-1:0];

	// Register write helpers
	assign lo_bits = (cmd.data[4:0] == 5'd0) ? ROM_LO_ONE : cmd.data[4:0];
	assign up_mask = (rom_bits == 3'd7) ? 2'b11 : 2'b01;

	// RAM store: one port, registered read data
	always_ff @(posedge clk) begin
		if (issue && cmd.op == OP_RAM_WR && ram_en_q) begin
			ram_q[ram_idx] <= cmd.data;
		end
		if (issue && cmd.op == OP_RAM_RD) begin
			rd_data_q <= ram_q[ram_idx];
		end
	end

	// Configuration and bank register updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_rom_bits_q <= CFG_W'(1);
			cfg_ram_cnt_q  <= CFG_W'(1);
			ram_en_q       <= 1'b0;
			bank_mode_q    <= 1'b0;
			rom_bank_q     <= ROM_BANK_W'(1);
			ram_blk_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROM_BANK_BITS:  cfg_rom_bits_q <= cfg_wdata;
					CFG_RAM_BANK_COUNT: cfg_ram_cnt_q  <= cfg_wdata;
					default:            cfg_rom_bits_q <= cfg_rom_bits_q;
				endcase
			end
			if (issue) begin
				case (cmd.op)
					OP_SET_RAM_EN: ram_en_q <= (cmd.data[3:0] == RAM_EN_KEY[3:0]);
					OP_SET_ROM_LO: rom_bank_q <= {rom_bank_q[6:5], lo_bits} & rom_mask;
					OP_SET_UPPER: begin
						if (rom_bits > 3'd5) begin
							rom_bank_q <= {cmd.data[1:0] & up_mask, rom_bank_q[4:0]};
						end
						if (ram_cnt > 3'd1) begin
							ram_blk_q <= cmd.data[1:0];
						end
					end
					OP_SET_MODE:   bank_mode_q <= cmd.data[0];
					default:       ram_en_q <= ram_en_q;
				endcase
			end
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (issue) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			op_s2     <= cmd.op;
			ram_en_s2 <= ram_en_q;
			if (cmd.op == OP_ROM_RD_FIXED || cmd.op == OP_ROM_RD_SWITCH) begin
				rom_addr_s2 <= {rd_bank, cmd.ofs};
			end else begin
				rom_addr_s2 <= '0;
			end
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.rom_address = rom_addr_s2;
	assign rsp.unmapped    = (op_s2 == OP_UNMAPPED);
	assign rsp.read_data   = (op_s2 != OP_RAM_RD) ? 8'h00 :
		(ram_en_s2 ? rd_data_q : RAM_OFF_DATA);

endmodule

// File: verif/mbc1_bank_checker.sv
// ----------------------------------------------------------------------------
// mbc1_bank_checker
// Watches the request, response and configuration ports of the MBC1 bank
// controller, predicts each response from its own copy of the bank state,
// and compares every response field by field in transaction order.
// ----------------------------------------------------------------------------
module mbc1_bank_checker import mbc1_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	mbc1_req_if              req,
	mbc1_rsp_if              rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);

	localparam int RAM_BANK_BYTES = 1 << RAM_OFS_W;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [ROM_ADDR_W-1:0] rom_address;
		logic [7:0]            read_data;
		logic                  unmapped;
	} bank_result_t;

	// Shadow configuration and bank registers
	logic [CFG_W-1:0]      rom_bits_reg;
	logic [CFG_W-1:0]      ram_count_reg;
	logic                  ram_en;
	logic                  bank_mode;
	logic [ROM_BANK_W-1:0] rom_bank;
	logic [RAM_BANK_W-1:0] ram_blk;
	logic [7:0]            ram_mirror [DEF_RAM_BANKS*RAM_BANK_BYTES];

	bank_result_t          expected_results [$];
	bank_result_t          oldest;

	// Bank bits beyond what the controller supports saturate
	function automatic int rom_bits_eff();
		int b = rom_bits_reg;
		return (b > DEF_MAX_ROM_BANK_BITS) ? DEF_MAX_ROM_BANK_BITS : b;
	endfunction

	// Zero bits means a single bank, so the mask is empty
	function automatic logic [ROM_BANK_W-1:0] rom_mask();
		return ROM_BANK_W'((1 << rom_bits_eff()) - 1);
	endfunction

	function automatic int ram_count_eff();
		int c = ram_count_reg;
		return (c > DEF_RAM_BANKS) ? DEF_RAM_BANKS : c;
	endfunction

	// RAM bank applies only in mode 1 with more than one bank present
	function automatic int ram_slot(logic [15:0] a);
		int cnt;
		int bank;
		cnt  = ram_count_eff();
		bank = (bank_mode && cnt > 1) ? ram_blk % cnt : 0;
		return bank * RAM_BANK_BYTES + a[RAM_OFS_W-1:0];
	endfunction

	// Applies one bus access to the shadow state and returns its response
	function automatic bank_result_t predict_access(logic [1:0] func, logic [15:0] a,
		logic [7:0] d);
		bank_result_t          r;
		logic [ROM_BANK_W-1:0] bank;
		logic [4:0]            low;
		logic [1:0]            up;
		int                    bits;
		r = '0;
		case (func)
		FUNC_ROM_RD: begin
			// Fixed area follows the upper bits only in mode 1
			if (a < 16'h4000)
				bank = bank_mode ? (rom_bank & ROM_BANK_HI) : '0;
			else
				bank = rom_bank;
			r.rom_address = {bank & rom_mask(), a[ROM_OFS_W-1:0]};
		end
		FUNC_ROM_WR: begin
			if (a[15]) begin
				r.unmapped = 1'b1;
			end else begin
				case (a[14:13])
				REGION_RAM_EN: ram_en = (d[3:0] == RAM_EN_KEY[3:0]);
				REGION_ROM_LO: begin
					low      = (d[4:0] == 5'd0) ? ROM_LO_ONE : d[4:0];
					rom_bank = ((rom_bank & ROM_BANK_HI) | {2'b00, low}) & rom_mask();
				end
				REGION_UPPER: begin
					bits = rom_bits_eff();
					if (bits > 5) begin
						up       = d[1:0] & 2'((1 << (bits - 5)) - 1);
						rom_bank = {up, rom_bank[4:0]};
					end
					if (ram_count_eff() > 1)
						ram_blk = d[1:0];
				end
				REGION_MODE: bank_mode = d[0];
				endcase
			end
		end
		FUNC_RAM_RD: r.read_data = ram_en ? ram_mirror[ram_slot(a)] : RAM_OFF_DATA;
		FUNC_RAM_WR: if (ram_en) ram_mirror[ram_slot(a)] = d;
		endcase
		return r;
	endfunction

	// Track configuration, predict on request, compare on response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bits_reg  = 3'd1;
			ram_count_reg = 3'd1;
			ram_en        = 1'b0;
			bank_mode     = 1'b0;
			rom_bank      = 7'd1;
			ram_blk       = '0;
			expected_results.delete();
			fail_count    = 0;
			pending       = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_ROM_BANK_BITS:  rom_bits_reg  = cfg_wdata;
				CFG_RAM_BANK_COUNT: ram_count_reg = cfg_wdata;
				endcase
			end

			if (req.valid && req.ready)
				expected_results.push_back(predict_access(req.func, req.addr, req.data));

			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display(
"ERROR %0t: response with no request pending: rom_address=%h read_data=%h unmapped=%b",
							$time, rsp.rom_address, rsp.read_data, rsp.unmapped);
				end else begin
					oldest = expected_results.pop_front();
					if (rsp.rom_address !== oldest.rom_address ||
						rsp.read_data !== oldest.read_data ||
						rsp.unmapped !== oldest.unmapped) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display(
"ERROR %0t: expected rom_address=%h read_data=%h unmapped=%b, got %h %h %b",
								$time, oldest.rom_address, oldest.read_data, oldest.unmapped,
								rsp.rom_address, rsp.read_data, rsp.unmapped);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: verif/tb_mbc1_bank_controller_top.sv
// ----------------------------------------------------------------------------
// tb_mbc1_bank_controller_top
// Drives bus accesses into the MBC1 bank controller: a directed set of edge
// cases, then random accesses under several bank configurations, with
// bursty requests and a stalling receiver. The checker judges responses.
// ----------------------------------------------------------------------------
module tb_mbc1_bank_controller_top;
	import mbc1_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int PHASES       = 8;
	localparam int HOT_SLOTS    = 16;
	localparam int RAM_SLOTS    = DEF_RAM_BANKS << RAM_OFS_W;

	typedef enum int {RX_OPEN, RX_BUSY_LIGHT, RX_BUSY_HEAVY, RX_TOGGLE} rx_pattern_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;

	mbc1_req_if req ();
	mbc1_rsp_if rsp ();

	// Bank settings visited by the random phases, extremes included
	logic [CFG_W-1:0] phase_rom_bits  [PHASES] = '{3'd7, 3'd0, 3'd5, 3'd6, 3'd3, 3'd7, 3'd2, 3'd1};
	logic [CFG_W-1:0] phase_ram_count [PHASES] = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd1, 3'd5, 3'd4};

	// What the stimulus needs to know to avoid reading unwritten RAM
	logic                  gen_ram_en;
	logic                  gen_mode;
	logic [RAM_BANK_W-1:0] gen_ram_blk;
	logic [CFG_W-1:0]      gen_ram_count;
	bit                    ram_written [RAM_SLOTS];
	logic [RAM_OFS_W-1:0]  ram_hot [HOT_SLOTS];
	int                    burst_left;
	bit                    long_stall;

	rx_pattern_t           rx_pattern;
	int                    rx_left;

	mbc1_bank_controller_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mbc1_bank_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Run limit
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// Store location a RAM access lands on under the current banking
	function automatic int ram_target(logic [15:0] a);
		int cnt;
		int bank;
		cnt  = (gen_ram_count > DEF_RAM_BANKS) ? DEF_RAM_BANKS : gen_ram_count;
		bank = (gen_mode && cnt > 1) ? gen_ram_blk % cnt : 0;
		return bank * (1 << RAM_OFS_W) + a[RAM_OFS_W-1:0];
	endfunction

	// One bus access: bursty request valid, held until the transaction
	task automatic send_access(input logic [1:0] func, input logic [15:0] a,
		input logic [7:0] d);
		logic [1:0] f;
		int         gap;
		f = func;
		// Never-written RAM has no defined value; write it instead
		if (f == FUNC_RAM_RD && gen_ram_en && !ram_written[ram_target(a)])
			f = FUNC_RAM_WR;
		case (f)
		FUNC_ROM_WR: begin
			if (!a[15]) begin
				case (a[14:13])
				REGION_RAM_EN: gen_ram_en = (d[3:0] == RAM_EN_KEY[3:0]);
				REGION_UPPER:  if (gen_ram_count > 1) gen_ram_blk = d[1:0];
				REGION_MODE:   gen_mode = d[0];
				default: ;
				endcase
			end
		end
		FUNC_RAM_WR: if (gen_ram_en) ram_written[ram_target(a)] = 1'b1;
		default: ;
		endcase

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;

		req.valid <= 1'b1;
		req.func  <= f;
		req.addr  <= a;
		req.data  <= d;
		do @(posedge clk); while (req.ready !== 1'b1);
	endtask

	// Random access mix, biased toward bank switching with RAM enabled
	task automatic random_access();
		int                   pick;
		logic [1:0]           f;
		logic [15:0]          a;
		logic [7:0]           d;
		logic [RAM_OFS_W-1:0] ofs;
		pick = $urandom_range(0, 99);
		d    = 8'($urandom);
		ofs  = ($urandom_range(0, 3) != 0) ? ram_hot[$urandom_range(0, HOT_SLOTS-1)]
			: RAM_OFS_W'($urandom);
		if (pick < 30) begin
			f = FUNC_ROM_RD;
			a = 16'($urandom);
		end else if (pick < 55) begin
			f = FUNC_ROM_WR;
			a = {1'b0, 2'($urandom), 13'($urandom)};
			if ($urandom_range(0, 19) == 0)
				a[15] = 1'b1;
			if (a[14:13] == REGION_RAM_EN && $urandom_range(0, 3) != 0)
				d[3:0] = RAM_EN_KEY[3:0];
			if (a[14:13] == REGION_ROM_LO && $urandom_range(0, 3) == 0)
				d[4:0] = 5'd0;
		end else begin
			f = (pick < 80) ? FUNC_RAM_RD : FUNC_RAM_WR;
			a = {($urandom_range(0, 3) != 0) ? 3'b101 : 3'($urandom), ofs};
		end
		send_access(f, a, d);
	endtask

	// Drain, then write both registers while nothing is in flight
	task automatic configure(input logic [CFG_W-1:0] rom_bits, input logic [CFG_W-1:0] ram_count);
		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROM_BANK_BITS;
		cfg_wdata <= rom_bits;
		@(posedge clk);
		cfg_index <= CFG_RAM_BANK_COUNT;
		cfg_wdata <= ram_count;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gen_ram_count = ram_count;
	endtask

	// Receiver: ready pattern changes per segment, plus requested long hold-offs
	initial begin
		rsp.ready = 1'b0;
		rx_left   = 0;
		forever begin
			@(posedge clk);
			if (long_stall) begin
				rsp.ready <= 1'b0;
				repeat (80) @(posedge clk);
				long_stall = 1'b0;
			end
			if (rx_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				rx_left    = $urandom_range(8, 60);
			end
			rx_left--;
			case (rx_pattern)
			RX_OPEN:       rsp.ready <= 1'b1;
			RX_BUSY_LIGHT: rsp.ready <= ($urandom_range(0, 3) != 0);
			RX_BUSY_HEAVY: rsp.ready <= ($urandom_range(0, 3) == 0);
			RX_TOGGLE:     rsp.ready <= ~rsp.ready;
			endcase
		end
	end

	// Stimulus and verdict
	initial begin
		req.valid     = 1'b0;
		req.func      = FUNC_ROM_RD;
		req.addr      = '0;
		req.data      = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_ROM_BANK_BITS;
		cfg_wdata     = '0;
		arst_n        = 1'b0;
		gen_ram_en    = 1'b0;
		gen_mode      = 1'b0;
		gen_ram_blk   = '0;
		gen_ram_count = 3'd1;
		burst_left    = 0;
		long_stall    = 1'b0;
		ram_hot[0]    = '0;
		ram_hot[1]    = '1;
		for (int i = 2; i < HOT_SLOTS; i++)
			ram_hot[i] = RAM_OFS_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edge cases under the reset configuration
		send_access(FUNC_ROM_RD, 16'h0000, 8'h00);
		send_access(FUNC_ROM_RD, 16'h7FFF, 8'hFF);
		send_access(FUNC_ROM_RD, 16'hFFFF, 8'h00);  // read above ROM space
		send_access(FUNC_RAM_RD, 16'hA000, 8'h00);  // RAM still disabled
		send_access(FUNC_RAM_WR, 16'hA000, 8'h55);  // dropped while disabled
		send_access(FUNC_ROM_WR, 16'h0000, 8'h0A);
		send_access(FUNC_RAM_WR, 16'hA000, 8'h00);
		send_access(FUNC_RAM_WR, 16'hBFFF, 8'hFF);
		send_access(FUNC_RAM_RD, 16'hA000, 8'h00);
		send_access(FUNC_RAM_RD, 16'hBFFF, 8'h00);
		send_access(FUNC_ROM_WR, 16'h2000, 8'h00);  // bank 0 becomes 1
		send_access(FUNC_ROM_WR, 16'h3FFF, 8'hFF);
		send_access(FUNC_ROM_RD, 16'h4000, 8'h00);
		send_access(FUNC_ROM_WR, 16'h4000, 8'h03);
		send_access(FUNC_ROM_WR, 16'h7FFF, 8'h01);
		send_access(FUNC_ROM_RD, 16'h3FFF, 8'h00);
		send_access(FUNC_ROM_WR, 16'h8000, 8'hFF);  // outside the registers
		send_access(FUNC_ROM_WR, 16'hFFFF, 8'h00);
		send_access(FUNC_RAM_RD, 16'hA000, 8'h00);
		send_access(FUNC_ROM_WR, 16'h1FFF, 8'hF0);
		send_access(FUNC_RAM_RD, 16'hBFFF, 8'h00);
		send_access(FUNC_ROM_WR, 16'h6000, 8'hFE);

		// Random phases, one bank configuration each
		for (int p = 0; p < PHASES; p++) begin
			configure(phase_rom_bits[p], phase_ram_count[p]);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if ((p == 1 || p == 5) && i == 40)
					long_stall = 1'b1;
				random_access();
			end
		end

		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
